FILE: rtl/sorted_unique_key_set_assert.svh
// assertion macros for the sorted key set checker
`ifndef SORTED_UNIQUE_KEY_SET_ASSERT_SVH
`define SORTED_UNIQUE_KEY_SET_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define SKSET_ASSERT_IMP(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SKSET_ASSERT_NXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: rtl/skset_pkg.sv
// types and codes shared by the sorted key set modules
package skset_pkg;

   // fixed field widths of the channels
   localparam int KEY_FIELD_W   = 16;
   localparam int STATUS_W      = 3;
   localparam int COUNT_FIELD_W = 5;

   // operation kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

   typedef struct packed {
      logic                   kind;
      logic [KEY_FIELD_W-1:0] key;
   } skset_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [COUNT_FIELD_W-1:0] count;
   } skset_rsp_type;

   // finished operation handed from the sequencer to the output stage
   typedef struct packed {
      logic          valid;
      skset_rsp_type beat;
   } skset_done_type;

endpackage

FILE: rtl/sorted_unique_key_set.sv
// sorted unique key set: top level with key store, sequencer and output register
//
// Keeps up to CAPACITY distinct keys in ascending order. Each req_ beat is an
// insert (kind 0) or a delete (kind 1) of one key; only the low KEY_WIDTH bits
// of the key count. Each item gives exactly one rsp_ beat with a status and
// the number of keys held afterwards (low 5 bits).
// Items are taken one at a time: req_stall is high from acceptance until the
// result has moved to the output register. The sequencer streams the key
// store one entry per cycle through its single read port, writing the
// rippled entry back in the same cycle; a duplicate, a full set or an
// absent key may end the walk early.
// The output register holds one result; while rsp_stall is high it keeps
// it and the next item is still taken and worked, then waits for the slot.
// Reset empties the set and drops any pending result; the key store itself
// is not cleared, entries are only read below the current count.
module sorted_unique_key_set #(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  skset_pkg::skset_req_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output skset_pkg::skset_rsp_type rsp_payload
);

   import skset_pkg::*;

   localparam int SK_W  = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
   localparam int IDX_W = $clog2(CAPACITY);

   logic             busy;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [SK_W-1:0]  mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [SK_W-1:0]  mem_rd_data;
   skset_done_type   done;
   logic             done_take;

   logic             rsp_valid_ff,   rsp_valid_in;
   skset_rsp_type    rsp_payload_ff, rsp_payload_in;

   skset_mem #(
      .DEPTH  (CAPACITY),
      .WIDTH  (SK_W),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   skset_ctrl #(
      .CAPACITY (CAPACITY),
      .SK_W     (SK_W),
      .IDX_W    (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .busy        (busy),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .done        (done),
      .done_take   (done_take)
   );

   // output register loads when empty or being drained
   assign done_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (done.valid && done_take) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = done.beat;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = busy;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: rtl/skset_mem.sv
// key store: one write port, one read port, registered read data
module skset_mem #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered output held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/skset_ctrl.sv
// walk sequencer: streams the key store, finds the slot and ripples entries
module skset_ctrl #(
   parameter int CAPACITY = 16,
   parameter int SK_W     = 16,
   parameter int IDX_W    = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  skset_pkg::skset_req_type   req_payload,
   output logic                       busy,
   output logic                       mem_wr_en,
   output logic [IDX_W-1:0]           mem_wr_addr,
   output logic [SK_W-1:0]            mem_wr_data,
   output logic                       mem_rd_en,
   output logic [IDX_W-1:0]           mem_rd_addr,
   input  logic [SK_W-1:0]            mem_rd_data,
   output skset_pkg::skset_done_type  done,
   input  logic                       done_take
);

   import skset_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]          state_ff,    state_in;
   logic [CNT_W-1:0]    count_ff,    count_in;
   logic [CNT_W-1:0]    nxt_ff,      nxt_in;
   logic                pend_ff,     pend_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                found_ff,    found_in;
   logic [SK_W-1:0]     carry_ff,    carry_in;
   logic                kind_ff,     kind_in;
   logic [SK_W-1:0]     key_ff,      key_in;
   logic [STATUS_W-1:0] stat_ff,     stat_in;

   // next state: search phase compares, shift phase ripples entries by one
   always_comb begin
      logic fin;
      fin         = 1'b0;
      state_in    = state_ff;
      count_in    = count_ff;
      nxt_in      = nxt_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      found_in    = found_ff;
      carry_in    = carry_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      stat_in     = stat_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = pend_idx_ff;
      mem_wr_data = carry_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = nxt_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_payload.kind;
               key_in   = SK_W'(req_payload.key);
               nxt_in   = '0;
               found_in = 1'b0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            // entry read last cycle is here now
            if (pend_ff) begin
               if (!found_ff) begin
                  if (mem_rd_data >= key_ff) begin
                     if (kind_ff == KIND_INSERT) begin
                        if (mem_rd_data == key_ff) begin
                           fin     = 1'b1;
                           stat_in = STAT_DUPLICATE;
                        end else if (count_ff == CAP_CNT) begin
                           fin     = 1'b1;
                           stat_in = STAT_FULL;
                        end else begin
                           mem_wr_en   = 1'b1;
                           mem_wr_addr = pend_idx_ff;
                           mem_wr_data = key_ff;
                           carry_in    = mem_rd_data;
                           found_in    = 1'b1;
                        end
                     end else begin
                        if (mem_rd_data == key_ff) begin
                           found_in = 1'b1;
                        end else begin
                           fin     = 1'b1;
                           stat_in = STAT_NOT_FOUND;
                        end
                     end
                  end
               end else if (kind_ff == KIND_INSERT) begin
                  // move the displaced key up one slot
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = pend_idx_ff;
                  mem_wr_data = carry_ff;
                  carry_in    = mem_rd_data;
               end else begin
                  // close the gap left by the deleted key
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = pend_idx_ff - 1'b1;
                  mem_wr_data = mem_rd_data;
               end
            end else if (nxt_ff == count_ff) begin
               // walked past the last entry
               fin = 1'b1;
               if (kind_ff == KIND_INSERT) begin
                  if (!found_ff && count_ff == CAP_CNT) begin
                     stat_in = STAT_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = count_ff[IDX_W-1:0];
                     mem_wr_data = found_ff ? carry_ff : key_ff;
                     count_in    = count_ff + 1'b1;
                     stat_in     = STAT_INSERTED;
                  end
               end else if (found_ff) begin
                  count_in = count_ff - 1'b1;
                  stat_in  = STAT_DELETED;
               end else if (count_ff == '0) begin
                  stat_in = STAT_EMPTY;
               end else begin
                  stat_in = STAT_NOT_FOUND;
               end
            end

            // issue the next read of the walk
            if (fin) begin
               state_in = S_DONE;
            end else if (nxt_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = nxt_ff[IDX_W-1:0];
               nxt_in      = nxt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (done_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   // walk payload registers
   always_ff @(posedge clock) begin
      nxt_ff      <= nxt_in;
      pend_idx_ff <= pend_idx_in;
      carry_ff    <= carry_in;
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      stat_ff     <= stat_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign done.valid        = (state_ff == S_DONE);
   assign done.beat.status  = stat_ff;
   assign done.beat.count   = COUNT_FIELD_W'(count_ff);

endmodule

FILE: rtl/skset_chk.sv
// port-level checker for the sorted key set, bound to the top level
`include "sorted_unique_key_set_assert.svh"

module skset_chk #(
   parameter int CAPACITY = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input skset_pkg::skset_req_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input skset_pkg::skset_rsp_type rsp_payload
);

   import skset_pkg::*;

   localparam logic [COUNT_FIELD_W-1:0] CAP_FIELD = COUNT_FIELD_W'(CAPACITY);

   logic req_beat;
   assign req_beat = req_valid && !req_stall && (req_payload.kind == KIND_INSERT ||
                                                 req_payload.kind == KIND_DELETE);

   // one item in flight: an accepted beat blocks the next one
   `SKSET_ASSERT_NXT(a_one_in_flight, req_beat, req_stall, "item accepted while busy")

   // only defined status codes come out
   `SKSET_ASSERT_IMP(a_status_code, rsp_valid, rsp_payload.status <= STAT_FULL, "bad status")

   // an empty report leaves nothing held
   `SKSET_ASSERT_IMP(a_empty_count, rsp_valid && rsp_payload.status == STAT_EMPTY, rsp_payload.count == '0, "empty with keys")

   // a full report shows the whole capacity
   `SKSET_ASSERT_IMP(a_full_count, rsp_valid && rsp_payload.status == STAT_FULL, rsp_payload.count == CAP_FIELD, "full below capacity")

   // a stalled result beat holds
   `SKSET_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "result changed under stall")

endmodule

bind sorted_unique_key_set skset_chk #(
   .CAPACITY (CAPACITY)
) u_skset_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

FILE: tb/tb_top.sv
// self-checking testbench for the sorted unique key set with a built-in set predictor
module tb_top;
   import skset_pkg::*;

   localparam int SET_DEPTH   = 16;
   localparam int PRINT_LIMIT = 40;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   skset_req_type req_payload = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   skset_rsp_type rsp_payload;

   // predictor state: keys held in ascending order
   logic [KEY_FIELD_W-1:0] held_keys[$];
   // outcomes still owed by the block, oldest first
   skset_rsp_type          pending_results[$];

   int mismatch_count = 0;
   int rsp_beats      = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;

   sorted_unique_key_set u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // clock: period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at rsp beat %0d: %s", rsp_beats, what);
      end
      mismatch_count++;
   endtask

   // apply one operation to the predicted set and return its outcome
   function automatic skset_rsp_type apply_key_op(input logic kind,
                                                  input logic [KEY_FIELD_W-1:0] key);
      int            pos;
      skset_rsp_type outcome;
      pos = 0;
      while (pos < held_keys.size() && held_keys[pos] < key) pos++;
      if (kind == KIND_INSERT) begin
         if (pos < held_keys.size() && held_keys[pos] == key) begin
            outcome.status = STAT_DUPLICATE;
         end else if (held_keys.size() >= SET_DEPTH) begin
            outcome.status = STAT_FULL;
         end else begin
            held_keys.insert(pos, key);
            outcome.status = STAT_INSERTED;
         end
      end else if (held_keys.size() == 0) begin
         outcome.status = STAT_EMPTY;
      end else if (pos >= held_keys.size() || held_keys[pos] != key) begin
         outcome.status = STAT_NOT_FOUND;
      end else begin
         held_keys.delete(pos);
         outcome.status = STAT_DELETED;
      end
      outcome.count = COUNT_FIELD_W'(held_keys.size());
      return outcome;
   endfunction

   task automatic set_idle(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // send one request beat, with random idle cycles ahead of it
   task automatic send_key_op(input logic kind, input logic [KEY_FIELD_W-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_payload.kind  <= kind;
      req_payload.key   <= key;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_key_op(kind, key));
   endtask

   // hold the request side idle until every owed result is out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // result side: check each accepted beat, then pick the next stall
   always @(posedge clock) begin
      skset_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_payload.status, want.status));
               end
               if (rsp_payload.count !== want.count) begin
                  report_mismatch($sformatf("count %0d, expected %0d",
                                            rsp_payload.count, want.count));
               end
            end
            rsp_beats++;
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // empty set, lone entry compared before removal
   task automatic test_empty_and_single();
      set_idle(0, 0);
      send_key_op(KIND_DELETE, 16'hFFFF);
      send_key_op(KIND_INSERT, 16'h8000);
      send_key_op(KIND_DELETE, 16'h7FFF);
      send_key_op(KIND_DELETE, 16'h8000);
   endtask

   // key extremes, duplicate, fill to capacity, full and duplicate-on-full, deletes on a full set
   task automatic test_fill_to_full();
      logic [3:0] k;
      send_key_op(KIND_INSERT, 16'h0000);
      send_key_op(KIND_INSERT, 16'hFFFF);
      send_key_op(KIND_INSERT, 16'h0000);
      for (int i = 0; i < SET_DEPTH - 2; i++) begin
         k = 4'((i * 7) % 15 + 1);
         send_key_op(KIND_INSERT, {k, 8'h00, k});
      end
      send_key_op(KIND_INSERT, 16'h0001);
      send_key_op(KIND_INSERT, 16'hFFFF);
      send_key_op(KIND_DELETE, 16'h7FFF);
      send_key_op(KIND_DELETE, 16'h0000);
   endtask

   // keys mostly drawn from the held set or a narrow range so hits are common
   function automatic logic [KEY_FIELD_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 45 && held_keys.size() != 0) begin
         return held_keys[$urandom_range(held_keys.size() - 1)];
      end else if (sel < 70) begin
         return KEY_FIELD_W'($urandom_range(31));
      end
      return KEY_FIELD_W'($urandom);
   endfunction

   // random operations in grow, shrink and mixed runs across idle phases
   task automatic test_random_ops(input int n_items);
      int insert_pct;
      insert_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 100 == 0) begin
            if (i % 400 == 0 && i > 0) wait_drained();
            case ((i / 100) % 4)
               0: begin
                  set_idle(0, 0);
               end
               1: begin
                  set_idle(61, 0);
               end
               2: begin
                  set_idle(0, 61);
               end
               default: begin
                  set_idle(20, 20);
               end
            endcase
         end
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0: insert_pct = 85;
               1: insert_pct = 15;
               default: insert_pct = 50;
            endcase
         end
         send_key_op(($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_DELETE,
                     pick_key());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_single();
      test_fill_to_full();
      test_random_ops(1400);
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
